FILE: hdl/ntc_pkg.sv
// Package: shared constants and codes of the normalized template correlator.
`default_nettype none
package ntc_pkg;
   localparam int DEF_MAX_PIXELS = 512;
   localparam int DEF_PIXEL_BITS = 16;
   localparam int PIX_FIELD_W    = 16;   // width of the pixel field on the bus
   localparam int CORR_W         = 16;   // Q1.15 result
   localparam int STATUS_W       = 2;
   localparam int CFG_W          = 10;   // pattern_pixels register
   localparam int CFG_RESET      = 300;
   localparam int K_BITS         = 16;   // magnitude search bits
   localparam int RHS_SHIFT      = 30;   // 2 * 15 fraction bits
   localparam int CSR_AW         = 3;
   localparam int CSR_DW         = 32;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FLAT     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

   localparam logic MODE_REF  = 1'b0;
   localparam logic MODE_CAND = 1'b1;
endpackage
`default_nettype wire

FILE: hdl/normalized_template_correlator.sv
// Top level: normalized template correlator with reference store and sequencer.
// Pixels stream one item per cycle when not held off, via a three-stage accumulate pipe.
// A candidate's last pixel starts the sequencer: eight V_W-bit shift-add multiplies, then
//   a bitwise search over K_BITS magnitude bits, steps S_SA, S_SB, S_SC per bit; only
//   four multiplies on a flat or mismatched pattern; no item is taken meanwhile.
// Reset: synchronous, active high; clears counts, sums, flags, output valid; store kept.
`default_nettype none
module normalized_template_correlator #(
   parameter int MAX_PIXELS = ntc_pkg::DEF_MAX_PIXELS,
   parameter int PIXEL_BITS = ntc_pkg::DEF_PIXEL_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input items
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [ntc_pkg::PIX_FIELD_W-1:0]   req_tdata,   // [15:0] pixel
   input  wire logic                              req_tuser,   // [0] mode
   input  wire logic                              req_tlast,   // last pixel of pattern
   // result items
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [ntc_pkg::CORR_W-1:0]             rsp_tdata,   // [15:0] correlation
   output logic [ntc_pkg::STATUS_W-1:0]           rsp_tuser,   // [1:0] status
   // configuration
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ntc_pkg::CSR_AW-1:0]        csr_paddr,
   input  wire logic [ntc_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [ntc_pkg::CSR_DW-1:0]             csr_prdata,
   output logic                                   csr_pready
);
   // widths derived from the pattern size and pixel depth
   localparam int LOG_W = $clog2(MAX_PIXELS);
   localparam int AW    = LOG_W;
   localparam int CNT_W = $clog2(MAX_PIXELS + 2);
   localparam int SUM_W = PIXEL_BITS + LOG_W;
   localparam int SQ_W  = 2 * PIXEL_BITS + LOG_W;
   localparam int PR_W  = 2 * PIXEL_BITS;
   localparam int V_W   = 2 * PIXEL_BITS + 2 * LOG_W;
   localparam int P_W   = 2 * V_W;
   localparam int T_W   = 2 * V_W + 33;
   localparam int MC_W  = $clog2(V_W);
   localparam int KB_W  = $clog2(ntc_pkg::K_BITS);
   localparam int K_W   = ntc_pkg::K_BITS;
   localparam int CMP_W = 32;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_SA   = 3'd2;
   localparam logic [2:0] S_SB   = 3'd3;
   localparam logic [2:0] S_SC   = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   // multiply operations in order
   localparam logic [2:0] OP_SXX = 3'd0;
   localparam logic [2:0] OP_VX  = 3'd1;
   localparam logic [2:0] OP_SYY = 3'd2;
   localparam logic [2:0] OP_VY  = 3'd3;
   localparam logic [2:0] OP_SXY = 3'd4;
   localparam logic [2:0] OP_A   = 3'd5;
   localparam logic [2:0] OP_DEN = 3'd6;
   localparam logic [2:0] OP_RHS = 3'd7;

   //------------------------------------------------------------------
   // configuration register
   //------------------------------------------------------------------
   logic [ntc_pkg::CFG_W-1:0] pp_ff;
   logic                      csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? '0 : ntc_pkg::CSR_DW'(pp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff <= ntc_pkg::CFG_W'(ntc_pkg::CFG_RESET);
      end else if (csr_wr) begin
         pp_ff <= csr_pwdata[ntc_pkg::CFG_W-1:0];
      end
   end

   //------------------------------------------------------------------
   // stage 0: accept, counts, store write and read address
   //------------------------------------------------------------------
   logic [PIXEL_BITS-1:0] ref_mem [MAX_PIXELS];
   logic [PIXEL_BITS-1:0] rdata_ff;

   logic             busy_ff;
   logic [CNT_W-1:0] rc_ff, rc_in, cc_ff, cc_in, rc_base;
   logic             closed_ff, closed_in;
   logic [CNT_W-1:0] snap_rc_ff, snap_cc_ff;
   logic             accept, acc_ref, acc_cand;
   logic [PIXEL_BITS-1:0] pix;
   logic             st_add, st_xp, cand_fire;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign acc_ref    = accept && (req_tuser == ntc_pkg::MODE_REF);
   assign acc_cand   = accept && (req_tuser == ntc_pkg::MODE_CAND);
   assign pix        = req_tdata[PIXEL_BITS-1:0];
   assign cand_fire  = acc_cand && req_tlast;

   always_comb begin
      rc_base   = closed_ff ? '0 : rc_ff;
      rc_in     = rc_ff;
      cc_in     = cc_ff;
      closed_in = closed_ff;
      st_add    = 1'b0;
      st_xp     = 1'b0;
      if (acc_ref) begin
         st_add    = (CMP_W'(rc_base) < CMP_W'(MAX_PIXELS));
         rc_in     = (CMP_W'(rc_base) <= CMP_W'(MAX_PIXELS)) ? rc_base + 1'b1 : rc_base;
         closed_in = req_tlast;
         cc_in     = '0;
      end else if (acc_cand) begin
         st_add = (CMP_W'(cc_ff) < CMP_W'(MAX_PIXELS));
         st_xp  = st_add && (cc_ff < rc_ff);
         cc_in  = (CMP_W'(cc_ff) <= CMP_W'(MAX_PIXELS)) ? cc_ff + 1'b1 : cc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_ff     <= '0;
         cc_ff     <= '0;
         closed_ff <= 1'b0;
      end else begin
         rc_ff     <= rc_in;
         cc_ff     <= cand_fire ? '0 : cc_in;
         closed_ff <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cand_fire) begin
         snap_rc_ff <= rc_ff;
         snap_cc_ff <= cc_in;
      end
   end

   // reference store: write at the reference position, read at the candidate position
   always_ff @(posedge clock) begin
      if (acc_ref && st_add) begin
         ref_mem[rc_base[AW-1:0]] <= pix;
      end
      rdata_ff <= ref_mem[cc_ff[AW-1:0]];
   end

   //------------------------------------------------------------------
   // stage 1: products
   //------------------------------------------------------------------
   logic                  s1_v_ff, s1_mode_ff, s1_start_ff, s1_add_ff, s1_xp_ff, s1_last_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff  <= req_tuser;
         s1_start_ff <= acc_ref && closed_ff;
         s1_add_ff   <= st_add;
         s1_xp_ff    <= st_xp;
         s1_last_ff  <= req_tlast;
         s1_pix_ff   <= pix;
      end
   end

   //------------------------------------------------------------------
   // stage 2: accumulate
   //------------------------------------------------------------------
   logic                  s2_v_ff, s2_mode_ff, s2_start_ff, s2_add_ff, s2_xp_ff, s2_last_ff;
   logic [PIXEL_BITS-1:0] s2_pix_ff;
   logic [PR_W-1:0]       s2_sq_ff, s2_xy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_start_ff <= s1_start_ff;
         s2_add_ff   <= s1_add_ff;
         s2_xp_ff    <= s1_xp_ff;
         s2_last_ff  <= s1_last_ff;
         s2_pix_ff   <= s1_pix_ff;
         s2_sq_ff    <= PR_W'(s1_pix_ff) * PR_W'(s1_pix_ff);
         s2_xy_ff    <= PR_W'(s1_pix_ff) * PR_W'(rdata_ff);
      end
   end

   logic [SUM_W-1:0] sx_ff, sy_ff;
   logic [SQ_W-1:0]  sxx_ff, syy_ff, sxy_ff;
   logic [2:0]       state_ff;
   logic             seq_start, seq_load;

   assign seq_start = s2_v_ff && (s2_mode_ff == ntc_pkg::MODE_CAND) && s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff  <= '0;
         sxx_ff <= '0;
         sy_ff  <= '0;
         syy_ff <= '0;
         sxy_ff <= '0;
      end else if (seq_load) begin
         sy_ff  <= '0;
         syy_ff <= '0;
         sxy_ff <= '0;
      end else if (s2_v_ff) begin
         if (s2_mode_ff == ntc_pkg::MODE_REF) begin
            sx_ff  <= (s2_start_ff ? '0 : sx_ff) +
                      (s2_add_ff ? SUM_W'(s2_pix_ff) : '0);
            sxx_ff <= (s2_start_ff ? '0 : sxx_ff) +
                      (s2_add_ff ? SQ_W'(s2_sq_ff) : '0);
            sy_ff  <= '0;
            syy_ff <= '0;
            sxy_ff <= '0;
         end else begin
            if (s2_add_ff) begin
               sy_ff  <= sy_ff + SUM_W'(s2_pix_ff);
               syy_ff <= syy_ff + SQ_W'(s2_sq_ff);
            end
            if (s2_xp_ff) begin
               sxy_ff <= sxy_ff + SQ_W'(s2_xy_ff);
            end
         end
      end
   end

   //------------------------------------------------------------------
   // result sequencer: shift-add multiplier, then bitwise magnitude search
   //------------------------------------------------------------------
   logic [2:0]               op_ff;
   logic [MC_W-1:0]          mc_ff;
   logic [P_W-1:0]           acc_ff, acc_in;
   logic [V_W-1:0]           ma, mb, hold_ff, vx_ff, vy_ff, mag_ff, prod_v, diff_v;
   logic                     neg_ff;
   logic [P_W-1:0]           den_ff;
   logic [T_W-1:0]           rhs_ff, t_ff, dk_ff, tmp_ff;
   logic [K_W-1:0]           k_ff;
   logic [KB_W-1:0]          b_ff;
   logic [ntc_pkg::STATUS_W-1:0] status_ff;
   logic [CNT_W-1:0]         nr, nc;
   logic                     mismatch, out_free;
   logic [ntc_pkg::CORR_W-1:0] corr;

   assign nr = (CMP_W'(snap_rc_ff) > CMP_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : snap_rc_ff;
   assign nc = (CMP_W'(snap_cc_ff) > CMP_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : snap_cc_ff;
   assign mismatch = (CMP_W'(pp_ff) > CMP_W'(MAX_PIXELS)) ||
                     (CMP_W'(snap_rc_ff) != CMP_W'(pp_ff)) ||
                     (CMP_W'(snap_cc_ff) != CMP_W'(pp_ff));

   always_comb begin
      case (op_ff)
         OP_SXX:  begin ma = V_W'(sx_ff);  mb = V_W'(sx_ff); end
         OP_VX:   begin ma = V_W'(sxx_ff); mb = V_W'(nr);    end
         OP_SYY:  begin ma = V_W'(sy_ff);  mb = V_W'(sy_ff); end
         OP_VY:   begin ma = V_W'(syy_ff); mb = V_W'(nc);    end
         OP_SXY:  begin ma = V_W'(sx_ff);  mb = V_W'(sy_ff); end
         OP_A:    begin ma = V_W'(sxy_ff); mb = V_W'(pp_ff); end
         OP_DEN:  begin ma = vx_ff;        mb = vy_ff;       end
         OP_RHS:  begin ma = mag_ff;       mb = mag_ff;      end
         default: begin ma = '0;           mb = '0;          end
      endcase
   end

   assign acc_in = (acc_ff << 1) + (mb[mc_ff] ? P_W'(ma) : '0);
   assign prod_v = acc_in[V_W-1:0];
   assign diff_v = prod_v - hold_ff;

   assign out_free = !rsp_tvalid || rsp_tready;
   assign seq_load = (state_ff == S_OUT) && out_free;

   always_comb begin
      if (status_ff != ntc_pkg::ST_OK) begin
         corr = '0;
      end else if (neg_ff) begin
         corr = ntc_pkg::CORR_W'(~k_ff + 1'b1);
      end else if (k_ff[K_W-1]) begin
         corr = {1'b0, {(ntc_pkg::CORR_W-1){1'b1}}};
      end else begin
         corr = ntc_pkg::CORR_W'(k_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         if (cand_fire) begin
            busy_ff <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (seq_start) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (mc_ff == '0) begin
                  if (op_ff == OP_VY) begin
                     if (vx_ff == '0 || diff_v == '0 || mismatch) begin
                        state_ff <= S_OUT;
                     end
                  end else if (op_ff == OP_RHS) begin
                     state_ff <= S_SA;
                  end
               end
            end
            S_SA: state_ff <= S_SB;
            S_SB: state_ff <= S_SC;
            S_SC: state_ff <= (b_ff == '0) ? S_OUT : S_SA;
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            op_ff     <= OP_SXX;
            mc_ff     <= MC_W'(V_W - 1);
            acc_ff    <= '0;
            status_ff <= ntc_pkg::ST_OK;
         end
         S_MUL: begin
            if (mc_ff != '0) begin
               acc_ff <= acc_in;
               mc_ff  <= mc_ff - 1'b1;
            end else begin
               acc_ff <= '0;
               mc_ff  <= MC_W'(V_W - 1);
               op_ff  <= op_ff + 1'b1;
               case (op_ff)
                  OP_SXX, OP_SYY, OP_SXY: hold_ff <= prod_v;
                  OP_VX: vx_ff <= diff_v;
                  OP_VY: begin
                     vy_ff <= diff_v;
                     if (vx_ff == '0 || diff_v == '0) begin
                        status_ff <= ntc_pkg::ST_FLAT;
                     end else if (mismatch) begin
                        status_ff <= ntc_pkg::ST_MISMATCH;
                     end
                  end
                  OP_A: begin
                     neg_ff <= prod_v < hold_ff;
                     mag_ff <= (prod_v < hold_ff) ? hold_ff - prod_v : diff_v;
                  end
                  OP_DEN: den_ff <= acc_in;
                  OP_RHS: begin
                     rhs_ff <= T_W'(acc_in) << ntc_pkg::RHS_SHIFT;
                     t_ff   <= '0;
                     dk_ff  <= '0;
                     k_ff   <= '0;
                     b_ff   <= KB_W'(K_W - 1);
                  end
                  default: hold_ff <= hold_ff;
               endcase
            end
         end
         // trial (k + 2^b)^2 * den = t + dk*2^(b+1) + den*2^(2b)
         S_SA: tmp_ff <= t_ff + (dk_ff << ({1'b0, b_ff} + 1'b1));
         S_SB: tmp_ff <= tmp_ff + (T_W'(den_ff) << {b_ff, 1'b0});
         S_SC: begin
            if (tmp_ff <= rhs_ff) begin
               t_ff       <= tmp_ff;
               dk_ff      <= dk_ff + (T_W'(den_ff) << b_ff);
               k_ff[b_ff] <= 1'b1;
            end
            b_ff <= b_ff - 1'b1;
         end
         default: op_ff <= op_ff;
      endcase
   end

   //------------------------------------------------------------------
   // output register
   //------------------------------------------------------------------
   logic                         rsp_v_ff;
   logic [ntc_pkg::CORR_W-1:0]   rsp_d_ff;
   logic [ntc_pkg::STATUS_W-1:0] rsp_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (seq_load) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_load) begin
         rsp_d_ff <= corr;
         rsp_s_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;
   assign rsp_tuser  = rsp_s_ff;

   //------------------------------------------------------------------
   // assertions
   //------------------------------------------------------------------
   a_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !(s1_v_ff || s2_v_ff))
      else $error("pixel pipeline active while the sequencer runs");

   a_zero_on_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ntc_pkg::ST_OK) |-> (rsp_tdata == '0))
      else $error("nonzero correlation with a failing status");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (CMP_W'(rc_ff) <= CMP_W'(MAX_PIXELS + 1)) && (CMP_W'(cc_ff) <= CMP_W'(MAX_PIXELS + 1)))
      else $error("pixel count beyond saturation");

   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(state_ff == S_OUT))
      else $error("result loaded outside the output state");

   a_busy_seq: assert property (@(posedge clock) disable iff (reset)
      seq_start |-> busy_ff)
      else $error("sequencer started without the input held off");
endmodule
`default_nettype wire
